>>> hdl/boron_pkg.sv
`timescale 1ns / 1ps

package boron_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned WordW  = 16;
  localparam int unsigned NibW   = 4;
  localparam int unsigned NumNib = BlockW / NibW;

  // beat modes
  localparam logic ModeLoad    = 1'b0;
  localparam logic ModeEncrypt = 1'b1;

  localparam logic [NibW-1:0] SBOX [16] = '{
    4'hE, 4'h4, 4'hB, 4'h1, 4'h7, 4'h9, 4'hC, 4'hA,
    4'hD, 4'h2, 4'h0, 4'hF, 4'h8, 4'h5, 4'h3, 4'h6
  };

  typedef logic [BlockW-1:0] block_t;

  // per-word rotate amounts
  localparam int unsigned Rot0 = 1;
  localparam int unsigned Rot1 = 4;
  localparam int unsigned Rot2 = 7;
  localparam int unsigned Rot3 = 9;

endpackage

>>> hdl/boron_ram.sv
`timescale 1ns / 1ps

module boron_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 26,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/boron_round.sv
`timescale 1ns / 1ps

module boron_round import boron_pkg::*; (
  input  block_t state_i,
  input  block_t key_i,
  output block_t state_o
);

  block_t            mixed_in;
  block_t            subst;
  logic [WordW-1:0]  shuf [4];
  logic [WordW-1:0]  rot [4];

  assign mixed_in = state_i ^ key_i;

  always_comb begin
    for (int n = 0; n < NumNib; n++) begin
      subst[n*NibW +: NibW] = SBOX[mixed_in[n*NibW +: NibW]];
    end
  end

  // nibbles (n3,n2,n1,n0) -> (n1,n0,n3,n2)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shuf[i] = {subst[i*WordW+4 +: 4], subst[i*WordW +: 4],
                 subst[i*WordW+12 +: 4], subst[i*WordW+8 +: 4]};
    end
  end

  assign rot[0] = (shuf[0] << Rot0) | (shuf[0] >> (WordW - Rot0));
  assign rot[1] = (shuf[1] << Rot1) | (shuf[1] >> (WordW - Rot1));
  assign rot[2] = (shuf[2] << Rot2) | (shuf[2] >> (WordW - Rot2));
  assign rot[3] = (shuf[3] << Rot3) | (shuf[3] >> (WordW - Rot3));

  assign state_o = {rot[3] ^ rot[2] ^ rot[0],
                    rot[2] ^ rot[0],
                    rot[3] ^ rot[1],
                    rot[3] ^ rot[1] ^ rot[0]};

endmodule

>>> hdl/boron_block_encrypt.sv
`timescale 1ns / 1ps

// BORON 64-bit block encryption with a loadable table of ROUNDS+1 round keys.
// A beat with mode 0 writes key_value into slot key_index (slots beyond the
// table are dropped) and gives no result; load beats are taken one per cycle.
// A beat with mode 1 encrypts plaintext: one round per cycle, each reading its
// round key from a single-port-read synchronous key table; a final XOR with the
// last key slot puts the ciphertext in the output register, held in S_HOLD while
// that register is full, and only then is the next beat taken. The
// output register lets a new beat in while a ciphertext still waits to be taken.
// Every slot must be loaded before the first encrypt; the table has no reset.
module boron_block_encrypt import boron_pkg::*; #(
  parameter int unsigned ROUNDS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [4:0]        key_index_i,
  input  logic [BlockW-1:0] key_value_i,
  input  logic [BlockW-1:0] plaintext_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BlockW-1:0] ciphertext_o
);

  localparam int unsigned KeySlots = ROUNDS + 1;
  localparam int unsigned AddrW    = $clog2(KeySlots);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  rnd_q, rnd_d;
  block_t            blk_q, blk_d;
  block_t            out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_beat;
  logic              out_free;
  logic              last_rnd;
  logic              ram_we;
  logic [AddrW-1:0]  ram_raddr;
  block_t            ram_rdata;
  block_t            rnd_out;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_rnd   = (rnd_q == AddrW'(ROUNDS));

  assign ram_we = in_beat && (mode_i == ModeLoad) &&
                  ({1'b0, key_index_i} < 6'(KeySlots));

  // next key is fetched in the cycle before its round
  always_comb begin
    if (state_q == S_RUN && !last_rnd) begin
      ram_raddr = rnd_q + AddrW'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  boron_ram #(
    .Width (BlockW),
    .Depth (KeySlots)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(key_index_i)),
    .wdata_i (key_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  boron_round u_round (
    .state_i (blk_q),
    .key_i   (ram_rdata),
    .state_o (rnd_out)
  );

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    blk_d       = blk_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat && (mode_i == ModeEncrypt)) begin
          blk_d   = plaintext_i;
          rnd_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (!last_rnd) begin
          blk_d = rnd_out;
          rnd_d = rnd_q + AddrW'(1);
        end else if (out_free) begin
          out_d       = blk_q ^ ram_rdata;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          blk_d   = blk_q ^ ram_rdata;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = blk_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ciphertext_o = out_q;

  a_table_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE)
    else $error("key table written during encryption");

  a_encrypt_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (mode_i == ModeEncrypt)) |=> (state_q == S_RUN && rnd_q == '0))
    else $error("encrypt beat did not start the round sequence");

  a_round_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> rnd_q <= AddrW'(ROUNDS))
    else $error("round counter past last key slot");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i) && $past(rst_ni))
      |-> ($past(state_q) == S_RUN || $past(state_q) == S_HOLD))
    else $error("result appeared without a finished encryption");

endmodule
